>>> rtl/fpce_pkg.sv
// Package for the planar pin-constraint evaluator: widths, CORDIC table,
// register indexes and the stage record passed along the CORDIC cell row.
package fpce_pkg;

  localparam int CordicStages = 16;
  localparam int AtanEntries  = 30;
  localparam int NumStages    = (CordicStages < AtanEntries) ? CordicStages : AtanEntries;
  localparam int StageW       = (NumStages > 1) ? $clog2(NumStages) : 1;

  localparam logic [33:0] GainStart = 34'sd652032874;

  localparam logic [2:0] RegAnchorX  = 3'd0;
  localparam logic [2:0] RegAnchorY  = 3'd1;
  localparam logic [2:0] RegTargetX  = 3'd2;
  localparam logic [2:0] RegTargetY  = 3'd3;
  localparam logic [2:0] RegStiff    = 3'd4;
  localparam logic [2:0] RegDamp     = 3'd5;

  typedef struct packed {
    logic               vld;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
    logic [1:0]         quad;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] rate;
  } cordic_slot_t;

  function automatic logic signed [32:0] atan_units(input logic [4:0] i);
    logic signed [32:0] v;
    case (i)
      5'd0:  v = 33'sh020000000;  5'd1:  v = 33'sh012E4051E;
      5'd2:  v = 33'sh009FB385B;  5'd3:  v = 33'sh0051111D4;
      5'd4:  v = 33'sh0028B0D43;  5'd5:  v = 33'sh00145D7E1;
      5'd6:  v = 33'sh000A2F61E;  5'd7:  v = 33'sh000517C55;
      5'd8:  v = 33'sh00028BE53;  5'd9:  v = 33'sh000145F2F;
      5'd10: v = 33'sh0000A2F98;  5'd11: v = 33'sh0000517CC;
      5'd12: v = 33'sh000028BE6;  5'd13: v = 33'sh0000145F3;
      5'd14: v = 33'sh00000A2F9;  5'd15: v = 33'sh00000517C;
      5'd16: v = 33'sh0000028BE;  5'd17: v = 33'sh00000145F;
      5'd18: v = 33'sh000000A2F;  5'd19: v = 33'sh000000517;
      5'd20: v = 33'sh00000028B;  5'd21: v = 33'sh000000145;
      5'd22: v = 33'sh0000000A2;  5'd23: v = 33'sh000000051;
      5'd24: v = 33'sh000000028;  5'd25: v = 33'sh000000014;
      5'd26: v = 33'sh00000000A;  5'd27: v = 33'sh000000005;
      5'd28: v = 33'sh000000002;  5'd29: v = 33'sh000000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/fpce_if.sv
// Valid/ready channel interfaces for the constraint evaluator.
// Depends on nothing.
interface fpce_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] angle;
  logic [31:0] angular_rate;
  modport source (output valid, pos_x, pos_y, angle, angular_rate, input ready);
  modport sink   (input valid, pos_x, pos_y, angle, angular_rate, output ready);
endinterface

interface fpce_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] error_x;
  logic [31:0] error_y;
  logic [31:0] jac_x_angle;
  logic [31:0] jac_y_angle;
  logic [31:0] jdot_x_angle;
  logic [31:0] jdot_y_angle;
  logic [30:0] gain_ks;
  logic [30:0] gain_kd;
  modport source (output valid, error_x, error_y, jac_x_angle, jac_y_angle,
                  jdot_x_angle, jdot_y_angle, gain_ks, gain_kd, input ready);
  modport sink   (input valid, error_x, error_y, jac_x_angle, jac_y_angle,
                  jdot_x_angle, jdot_y_angle, gain_ks, gain_kd, output ready);
endinterface

interface fpce_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/fpce_cell.sv
// One CORDIC rotation cell: a single micro-rotation, registered.
// Depends on fpce_pkg.
module fpce_cell
  import fpce_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [4:0]   stage,
  input  cordic_slot_t slot_in,
  output cordic_slot_t slot_out
);

  cordic_slot_t slot_r, slot_nxt;
  logic signed [33:0] dx, dy;
  logic signed [32:0] at;

  always_comb begin
    dx = slot_in.y >>> stage;
    dy = slot_in.x >>> stage;
    at = atan_units(stage);
    slot_nxt = slot_in;
    if (!slot_in.z[32]) begin
      slot_nxt.x = slot_in.x - dx;
      slot_nxt.y = slot_in.y + dy;
      slot_nxt.z = slot_in.z - at;
    end else begin
      slot_nxt.x = slot_in.x + dx;
      slot_nxt.y = slot_in.y - dy;
      slot_nxt.z = slot_in.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.vld <= 1'b0;
    end else if (en) begin
      slot_r <= slot_nxt;
    end
  end

  assign slot_out = slot_r;

endmodule

>>> rtl/fpce_post.sv
// Back end: quadrant turn, anchor rotation, errors and rate products.
// Depends on fpce_pkg. Three registered stages, at most one multiply level each.
module fpce_post
  import fpce_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  cordic_slot_t slot_in,
  input  logic [31:0]  lx,
  input  logic [31:0]  ly,
  input  logic [31:0]  tx,
  input  logic [31:0]  ty,
  output logic         vld,
  output logic [31:0]  res_ex,
  output logic [31:0]  res_ey,
  output logic [31:0]  res_jx,
  output logic [31:0]  res_jy,
  output logic [31:0]  res_dx,
  output logic [31:0]  res_dy
);

  // stage A: products
  logic               a_vld_r;
  logic signed [65:0] a_clx_r, a_sly_r, a_slx_r, a_cly_r;
  logic signed [31:0] a_px_r, a_py_r, a_rate_r;
  logic signed [33:0] c, s;
  // stage B: rotated anchor
  logic               b_vld_r;
  logic signed [31:0] b_rx_r, b_ry_r, b_px_r, b_py_r, b_rate_r;
  logic signed [66:0] sum_x, sum_y;
  // stage C: rate products
  logic               c_vld_r;
  logic signed [63:0] c_mx_r, c_my_r;
  logic signed [31:0] c_ex_r, c_ey_r, c_rx_r, c_ry_r;

  always_comb begin
    case (slot_in.quad)
      2'd0:    begin c = slot_in.x;  s = slot_in.y;  end
      2'd1:    begin c = -slot_in.y; s = slot_in.x;  end
      2'd2:    begin c = -slot_in.x; s = -slot_in.y; end
      default: begin c = slot_in.y;  s = -slot_in.x; end
    endcase
    sum_x = 67'(a_clx_r) - 67'(a_sly_r);
    sum_y = 67'(a_slx_r) + 67'(a_cly_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= slot_in.vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_clx_r  <= 66'(c * $signed(lx));
      a_sly_r  <= 66'(s * $signed(ly));
      a_slx_r  <= 66'(s * $signed(lx));
      a_cly_r  <= 66'(c * $signed(ly));
      a_px_r   <= slot_in.pos_x;
      a_py_r   <= slot_in.pos_y;
      a_rate_r <= slot_in.rate;
      b_rx_r   <= sum_x[61:30];
      b_ry_r   <= sum_y[61:30];
      b_px_r   <= a_px_r;
      b_py_r   <= a_py_r;
      b_rate_r <= a_rate_r;
      c_mx_r   <= b_rate_r * b_rx_r;
      c_my_r   <= b_rate_r * b_ry_r;
      c_ex_r   <= b_px_r + b_rx_r - $signed(tx);
      c_ey_r   <= b_py_r + b_ry_r - $signed(ty);
      c_rx_r   <= b_rx_r;
      c_ry_r   <= b_ry_r;
    end
  end

  logic signed [63:0] neg_mx, neg_my;
  assign neg_mx = -c_mx_r;
  assign neg_my = -c_my_r;
  assign vld    = c_vld_r;
  assign res_ex = c_ex_r;
  assign res_ey = c_ey_r;
  assign res_jx = -c_ry_r;
  assign res_jy = c_rx_r;
  assign res_dx = neg_mx[47:16];
  assign res_dy = neg_my[47:16];

endmodule

>>> rtl/fixed_point_constraint_eval.sv
// Planar pin-constraint evaluator, top level.
// Depends on fpce_pkg, fpce_if, fpce_cell and fpce_post.
//
// One body pose per cycle in, one result per cycle out. The pipe holds
// an input register with quadrant reduction, one register per CORDIC
// cell, three back-end stages (products, anchor rotation, rate
// multiply) and the output register. The whole pipe advances when the
// output register is empty or being drained; a stall at the output holds
// every stage.
module fixed_point_constraint_eval
  import fpce_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  fpce_in_if.sink    in_ch,
  fpce_out_if.source out_ch,
  fpce_cfg_if.sink   cfg_ch
);

  logic [31:0] lx_r, ly_r, tx_r, ty_r;
  logic [30:0] ks_r, kd_r;
  logic        en;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lx_r <= '0;
      ly_r <= '0;
      tx_r <= '0;
      ty_r <= '0;
      ks_r <= 31'd655360;
      kd_r <= 31'd65536;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        RegAnchorX: lx_r <= cfg_ch.data;
        RegAnchorY: ly_r <= cfg_ch.data;
        RegTargetX: tx_r <= cfg_ch.data;
        RegTargetY: ty_r <= cfg_ch.data;
        RegStiff:   ks_r <= cfg_ch.data[30:0];
        RegDamp:    kd_r <= cfg_ch.data[30:0];
        default: ;
      endcase
    end
  end

  logic out_vld_r;
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // input register: angle reduction
  cordic_slot_t head_r, head_nxt;
  logic [31:0]  qsum;
  always_comb begin
    qsum           = in_ch.angle + 32'h2000_0000;
    head_nxt.vld   = in_ch.valid;
    head_nxt.quad  = qsum[31:30];
    head_nxt.z     = 33'($signed(in_ch.angle - {qsum[31:30], 30'd0}));
    head_nxt.x     = GainStart;
    head_nxt.y     = '0;
    head_nxt.pos_x = in_ch.pos_x;
    head_nxt.pos_y = in_ch.pos_y;
    head_nxt.rate  = in_ch.angular_rate;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.vld <= 1'b0;
    end else if (en) begin
      head_r <= head_nxt;
    end
  end

  cordic_slot_t chain [0:NumStages];
  assign chain[0] = head_r;

  for (genvar g = 0; g < NumStages; g++) begin : g_cell
    fpce_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .stage    (5'(g)),
      .slot_in  (chain[g]),
      .slot_out (chain[g+1])
    );
  end

  logic        p_vld;
  logic [31:0] p_ex, p_ey, p_jx, p_jy, p_dx, p_dy;

  fpce_post u_post (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .slot_in (chain[NumStages]),
    .lx      (lx_r),
    .ly      (ly_r),
    .tx      (tx_r),
    .ty      (ty_r),
    .vld     (p_vld),
    .res_ex  (p_ex),
    .res_ey  (p_ey),
    .res_jx  (p_jx),
    .res_jy  (p_jy),
    .res_dx  (p_dx),
    .res_dy  (p_dy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= p_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.error_x      <= p_ex;
      out_ch.error_y      <= p_ey;
      out_ch.jac_x_angle  <= p_jx;
      out_ch.jac_y_angle  <= p_jy;
      out_ch.jdot_x_angle <= p_dx;
      out_ch.jdot_y_angle <= p_dy;
      out_ch.gain_ks      <= ks_r;
      out_ch.gain_kd      <= kd_r;
    end
  end

  assign out_ch.valid = out_vld_r;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> out_vld_r && $stable(out_ch.error_x))
    else $error("result changed while stalled");
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ch.ready)
    else $error("input blocked with empty output");
`endif

endmodule
